/* sv/fbfla_pkg.sv */
package fbfla_pkg;

  // Pool geometry.
  localparam int NUM_BLOCKS      = 128;
  localparam int IDX_W           = $clog2(NUM_BLOCKS);
  localparam int CNT_W           = 8;
  localparam int MIN_BLOCK_BYTES = 8;

  // Reset values of the configuration registers.
  localparam logic [15:0]      RST_BLOCK_BYTES = 16'd32;
  localparam logic [CNT_W-1:0] RST_POOL_BLOCKS = 8'd100;
  localparam logic [31:0]      RST_POOL_BASE   = 32'd0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_BYTES = 2'd0;
  localparam logic [1:0] CFG_POOL_BLOCKS = 2'd1;
  localparam logic [1:0] CFG_POOL_BASE   = 2'd2;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ADDR
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request word
    logic exec;    // update the free list and counters
    logic finish;  // form the granted address
  } cmd_t;

endpackage

/* sv/fbfla_ctrl.sv */
module fbfla_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output fbfla_pkg::cmd_t  cmd
);

  fbfla_pkg::state_t state;
  fbfla_pkg::state_t state_next;

  // State register and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfla_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == fbfla_pkg::ST_ADDR);
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      fbfla_pkg::ST_IDLE: begin
        if (start) begin
          state_next = fbfla_pkg::ST_EXEC;
        end
      end
      fbfla_pkg::ST_EXEC: begin
        state_next = fbfla_pkg::ST_ADDR;
      end
      fbfla_pkg::ST_ADDR: begin
        state_next = fbfla_pkg::ST_IDLE;
      end
      default: begin
        state_next = fbfla_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.exec   = 1'b0;
    cmd.finish = 1'b0;
    case (state)
      fbfla_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      fbfla_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      fbfla_pkg::ST_ADDR: begin
        cmd.finish = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // An accepted request always moves into the execute step.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == fbfla_pkg::ST_EXEC))
    else $error("accepted request did not reach execute");

  // The strobe follows the address step exactly.
  a_done_after_addr: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == fbfla_pkg::ST_ADDR))
    else $error("result strobe without address step");

  // A result is shown only while the controller is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");
`endif

endmodule

/* sv/fbfla_datapath.sv */
module fbfla_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  fbfla_pkg::cmd_t                  cmd,
  input  logic                             kind,
  input  logic [fbfla_pkg::IDX_W-1:0]      block_index,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [31:0]                      cfg_data,
  output logic [1:0]                       status,
  output logic [fbfla_pkg::IDX_W-1:0]      granted_index,
  output logic [31:0]                      granted_address,
  output logic [fbfla_pkg::CNT_W-1:0]      free_count
);

  localparam int IW = fbfla_pkg::IDX_W;
  localparam int CW = fbfla_pkg::CNT_W;
  localparam int PW = IW + 16;

  // Link store: each entry holds {link valid, next freed block}.
  logic [IW:0] link_mem [fbfla_pkg::NUM_BLOCKS];
  logic [IW:0] link_rd;

  // Configuration registers.
  logic [15:0]   block_bytes;
  logic [CW-1:0] pool_blocks;
  logic [31:0]   pool_base;

  // Free-list state.
  logic [IW-1:0] freed_head;
  logic          head_valid;
  logic [CW-1:0] never_used_next;
  logic [CW-1:0] free_blocks;

  // Captured request word.
  logic          req_kind;
  logic [IW-1:0] req_index;

  // Registered product and grant flag for the address step.
  logic [PW-1:0] product;
  logic          granted;

  logic [CW-1:0] eff_blocks;
  logic [CW-1:0] eff_cfg;
  logic          usable;

  logic [IW-1:0] freed_head_next;
  logic          head_valid_next;
  logic [CW-1:0] never_used_next_next;
  logic [CW-1:0] free_blocks_next;
  logic [1:0]    status_next;
  logic [IW-1:0] gidx_next;
  logic          granted_next;
  logic          push;

  // Effective block count is the written count clamped to the pool size.
  always_comb begin
    eff_blocks = (pool_blocks < CW'(fbfla_pkg::NUM_BLOCKS)) ?
                 pool_blocks : CW'(fbfla_pkg::NUM_BLOCKS);
    eff_cfg    = (cfg_data[CW-1:0] < CW'(fbfla_pkg::NUM_BLOCKS)) ?
                 cfg_data[CW-1:0] : CW'(fbfla_pkg::NUM_BLOCKS);
    usable     = (block_bytes >= 16'(fbfla_pkg::MIN_BLOCK_BYTES));
  end

  // Decision for one request: pop the freed stack, take a fresh block, push, or reject.
  always_comb begin
    freed_head_next      = freed_head;
    head_valid_next      = head_valid;
    never_used_next_next = never_used_next;
    free_blocks_next     = free_blocks;
    status_next          = fbfla_pkg::STAT_OK;
    gidx_next            = '0;
    granted_next         = 1'b0;
    push                 = 1'b0;
    if (!usable) begin
      status_next = (req_kind == fbfla_pkg::KIND_FREE) ?
                    fbfla_pkg::STAT_INVALID : fbfla_pkg::STAT_EXHAUSTED;
    end else if (req_kind == fbfla_pkg::KIND_ALLOC) begin
      if (head_valid) begin
        gidx_next       = freed_head;
        head_valid_next = link_rd[IW];
        freed_head_next = link_rd[IW-1:0];
        granted_next    = 1'b1;
      end else if (never_used_next < eff_blocks) begin
        gidx_next            = never_used_next[IW-1:0];
        never_used_next_next = never_used_next + CW'(1);
        granted_next         = 1'b1;
      end
      if (granted_next) begin
        if (free_blocks != '0) begin
          free_blocks_next = free_blocks - CW'(1);
        end
      end else begin
        status_next = fbfla_pkg::STAT_EXHAUSTED;
      end
    end else begin
      if ({1'b0, req_index} < eff_blocks) begin
        push            = 1'b1;
        freed_head_next = req_index;
        head_valid_next = 1'b1;
        if (free_blocks != '1) begin
          free_blocks_next = free_blocks + CW'(1);
        end
      end else begin
        status_next = fbfla_pkg::STAT_INVALID;
      end
    end
  end

  // Link store: registered read of the head entry, write on a push.
  always_ff @(posedge clk) begin
    link_rd <= link_mem[freed_head];
    if (cmd.exec && push) begin
      link_mem[req_index] <= {head_valid, freed_head};
    end
  end

  // Configuration and free-list control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes     <= fbfla_pkg::RST_BLOCK_BYTES;
      pool_blocks     <= fbfla_pkg::RST_POOL_BLOCKS;
      pool_base       <= fbfla_pkg::RST_POOL_BASE;
      freed_head      <= '0;
      head_valid      <= 1'b0;
      never_used_next <= '0;
      free_blocks     <= (fbfla_pkg::RST_POOL_BLOCKS < CW'(fbfla_pkg::NUM_BLOCKS)) ?
                         fbfla_pkg::RST_POOL_BLOCKS : CW'(fbfla_pkg::NUM_BLOCKS);
    end else if (cfg_we) begin
      case (cfg_index)
        fbfla_pkg::CFG_BLOCK_BYTES: begin
          block_bytes <= cfg_data[15:0];
        end
        fbfla_pkg::CFG_POOL_BLOCKS: begin
          pool_blocks     <= cfg_data[CW-1:0];
          freed_head      <= '0;
          head_valid      <= 1'b0;
          never_used_next <= '0;
          free_blocks     <= eff_cfg;
        end
        fbfla_pkg::CFG_POOL_BASE: begin
          pool_base <= cfg_data;
        end
        default: begin
          pool_base <= pool_base;
        end
      endcase
    end else if (cmd.exec) begin
      freed_head      <= freed_head_next;
      head_valid      <= head_valid_next;
      never_used_next <= never_used_next_next;
      free_blocks     <= free_blocks_next;
    end
  end

  // Request capture, result fields and the address step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind  <= kind;
      req_index <= block_index;
    end
    if (cmd.exec) begin
      status        <= status_next;
      granted_index <= gidx_next;
      granted       <= granted_next;
      product       <= PW'(gidx_next) * PW'(block_bytes);
      free_count    <= usable ? free_blocks_next : '0;
    end
    if (cmd.finish) begin
      granted_address <= granted ? (pool_base + 32'(product)) : 32'd0;
    end
  end

endmodule

/* sv/fixed_block_free_list_allocator_unit.sv */
// Free-list allocator for equal-size blocks.
// Request channel: drive kind (allocate or free) and block_index with start;
// the word is taken at a rising edge where start is high and busy is low.
// An allocate pops the most recently freed block, or else the next block
// never handed out; a free pushes block_index back on the freed stack.
// Result channel: done is high for exactly one cycle while status,
// granted_index, granted_address and free_count hold the result; the
// receiver cannot stall and must take the word in that cycle.
// Sequence: the execute step, then the address step; done is registered
// from the address step and busy stays high until it shows. A new request
// can be taken in the cycle that done is shown. The steps are a registered
// link-store read, the list update with the index times block_bytes product, and the base add.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 block_bytes, 1 pool_blocks, 2 pool_base); cfg_ready is always high.
// Writing pool_blocks empties the freed stack and restarts the fresh count.
// Reset: synchronous rst restores block_bytes 32, pool_blocks 100,
// pool_base 0 and an empty freed stack with 100 free blocks.
module fixed_block_free_list_allocator_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [fbfla_pkg::IDX_W-1:0]  block_index,
  output logic                         done,
  output logic [1:0]                   status,
  output logic [fbfla_pkg::IDX_W-1:0]  granted_index,
  output logic [31:0]                  granted_address,
  output logic [fbfla_pkg::CNT_W-1:0]  free_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);

  fbfla_pkg::cmd_t cmd;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  fbfla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  fbfla_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .kind            (kind),
    .block_index     (block_index),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .status          (status),
    .granted_index   (granted_index),
    .granted_address (granted_address),
    .free_count      (free_count)
  );

endmodule
